### rtl/core/rfq_pkg.sv
// shared types, codes and constants of the receive frame queue
package rfq_pkg;

	localparam int DEF_NUM_SLOTS  = 3;
	localparam int DEF_SLOT_BYTES = 128;

	// slot offsets are kept one bit wider than a byte so that length plus one fits
	localparam int OFF_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RSSI_RAW  = 1'd1;

	localparam logic [2:0] REQ_START   = 3'd0;
	localparam logic [2:0] REQ_BYTE    = 3'd1;
	localparam logic [2:0] REQ_READ    = 3'd2;
	localparam logic [2:0] REQ_RELEASE = 3'd3;
	localparam logic [2:0] REQ_FLUSH   = 3'd4;

	localparam logic [3:0] STS_ACCEPTED    = 4'd0;
	localparam logic [3:0] STS_REJECTED    = 4'd1;
	localparam logic [3:0] STS_STORED      = 4'd2;
	localparam logic [3:0] STS_COMMITTED   = 4'd3;
	localparam logic [3:0] STS_CRC_FAIL    = 4'd4;
	localparam logic [3:0] STS_READ        = 4'd5;
	localparam logic [3:0] STS_EMPTY       = 4'd6;
	localparam logic [3:0] STS_RELEASED    = 4'd7;
	localparam logic [3:0] STS_REL_IGNORED = 4'd8;
	localparam logic [3:0] STS_FLUSHED     = 4'd9;
	localparam logic [3:0] STS_BYTE_IGN    = 4'd10;

	localparam logic [7:0] RSSI_OFFSET = 8'd56;
	localparam logic [7:0] MIN_LEN     = 8'd3;
	localparam logic [7:0] MAX_LEN     = 8'd127;
	localparam int         CRC_OK_BIT  = 7;

	typedef enum logic [1:0] {
		RD_LEN,
		RD_LQI,
		RD_RSSI,
		RD_DATA
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COMMIT,
		ST_R1,
		ST_R2,
		ST_R3,
		ST_R4
	} state_t;

	typedef struct packed {
		logic    load_in;
		logic    wr_byte;
		logic    wr_rssi;
		logic    rd_issue;
		rd_sel_t rd_sel;
		logic    rd_cap;
		logic    fin;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       capturing;
		logic       last_byte;
		logic       commit_ok;
		logic       empty;
	} dp_stat_t;

endpackage

### rtl/core/rfq_if.sv
// request and response channel interfaces of the receive frame queue
interface rfq_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] frame_length;
	logic [7:0] first_byte;
	logic [7:0] byte_in;
	logic [6:0] byte_index;

	modport source (
		output valid, req_type, frame_length, first_byte, byte_in, byte_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, frame_length, first_byte, byte_in, byte_index,
		output ready
	);
endinterface

interface rfq_rsp_if;
	logic              valid;
	logic              ready;
	logic        [3:0] status;
	logic        [6:0] payload_len;
	logic        [6:0] lqi;
	logic signed [7:0] rssi;
	logic        [7:0] data_byte;
	logic        [1:0] free_slots;

	modport source (
		output valid, status, payload_len, lqi, rssi, data_byte, free_slots,
		input  ready
	);
	modport sink (
		input  valid, status, payload_len, lqi, rssi, data_byte, free_slots,
		output ready
	);
endinterface

### rtl/core/rfq_dp.sv
// datapath of the receive frame queue: frame store, queue state and result register
module rfq_dp import rfq_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [2:0]            req_type,
	input  logic [7:0]            frame_length,
	input  logic [7:0]            first_byte,
	input  logic [7:0]            byte_in,
	input  logic [6:0]            byte_index,
	output logic [3:0]            status,
	output logic [6:0]            payload_len,
	output logic [6:0]            lqi,
	output logic signed [7:0]     rssi,
	output logic [7:0]            data_byte,
	output logic [1:0]            free_slots
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int DEPTH  = NUM_SLOTS * SLOT_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [OFF_W-1:0]  SLOT_END  = OFF_W'(SLOT_BYTES);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0]  ALL_FREE  = CNT_W'(NUM_SLOTS);

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
		input logic [OFF_W-1:0] o);
		return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(o);
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	// latched transaction
	logic [2:0] req_q;
	logic [7:0] len_q;
	logic [7:0] first_q;
	logic [7:0] byte_q;
	logic [6:0] bidx_q;

	logic              rx_en_q;
	logic [7:0]        rssi_raw_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [CNT_W-1:0]  free_q;
	logic              capturing_q;
	logic [7:0]        byte_pos_q;
	logic [7:0]        cur_len_q;

	logic [SLOT_W-1:0] write_slot_nxt;
	logic [SLOT_W-1:0] read_slot_nxt;
	logic [CNT_W-1:0]  free_nxt;
	logic              capturing_nxt;
	logic [7:0]        byte_pos_nxt;
	logic [7:0]        cur_len_nxt;

	logic [7:0] flen_q;
	logic [6:0] lqi_q;
	logic [7:0] rssi_q;

	logic [7:0]  mem [DEPTH];
	logic [7:0]  rdata_q;
	logic        rok_q;
	rd_sel_t     rtag_q;
	logic [7:0]  rd_val;

	logic             start_ok;
	logic             last_byte;
	logic             crc_ok;
	logic             commit_ok;
	logic             empty;
	logic [OFF_W-1:0] pos_off;
	logic [OFF_W-1:0] woff;
	logic [7:0]       wdata;
	logic             wsel;
	logic             mem_we;
	logic [OFF_W-1:0] roff;
	logic [6:0]       plen_cur;
	logic [7:0]       data_now;

	logic [3:0]        status_nxt;
	logic [6:0]        plen_nxt;
	logic [6:0]        lqi_nxt;
	logic [7:0]        rssi_nxt;
	logic [7:0]        data_nxt;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q   <= req_type;
			len_q   <= frame_length;
			first_q <= first_byte;
			byte_q  <= byte_in;
			bidx_q  <= byte_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q    <= 1'b0;
			rssi_raw_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RX_ENABLE: rx_en_q <= cfg_data[0];
				CFG_RSSI_RAW:  rssi_raw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos_off   = {1'b0, byte_pos_q} + OFF_W'(1);
	assign empty     = (free_q >= ALL_FREE);
	assign start_ok  = (len_q >= MIN_LEN) && (len_q <= MAX_LEN) &&
	                   ((first_q + 8'd1) == len_q) && rx_en_q && (free_q != '0);
	assign last_byte = (pos_off >= {1'b0, cur_len_q});
	// the last byte lands at offset cur_len, outside the slot it reads back as zero
	assign crc_ok    = ({1'b0, cur_len_q} < SLOT_END) && byte_q[CRC_OK_BIT];
	assign commit_ok = crc_ok && (free_q != '0);

	assign stat.req       = req_q;
	assign stat.capturing = capturing_q;
	assign stat.last_byte = last_byte;
	assign stat.commit_ok = commit_ok;
	assign stat.empty     = empty;

	// store write port
	always_comb begin
		woff  = '0;
		wdata = len_q;
		wsel  = cmd.fin && (req_q == REQ_START) && start_ok;
		if (cmd.wr_rssi) begin
			woff  = {1'b0, cur_len_q} - OFF_W'(1);
			wdata = rssi_raw_q - RSSI_OFFSET;
			wsel  = 1'b1;
		end else if (cmd.wr_byte) begin
			woff  = pos_off;
			wdata = byte_q;
			wsel  = 1'b1;
		end
	end

	assign mem_we = wsel && (woff < SLOT_END);

	// store read port
	always_comb begin
		unique case (cmd.rd_sel)
			RD_LEN:  roff = '0;
			RD_LQI:  roff = {1'b0, rd_val};
			RD_RSSI: roff = {1'b0, flen_q} - OFF_W'(1);
			RD_DATA: roff = {2'b00, bidx_q} + OFF_W'(1);
			default: roff = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[slot_addr(write_slot_q, woff)] <= wdata;
		if (cmd.rd_issue) begin
			rdata_q <= mem[slot_addr(read_slot_q, roff)];
			rok_q   <= (roff < SLOT_END);
			rtag_q  <= cmd.rd_sel;
		end
	end

	assign rd_val   = rok_q ? rdata_q : 8'd0;
	assign plen_cur = 7'(flen_q - 8'd2);
	assign data_now = (bidx_q < plen_cur) ? rd_val : 8'd0;

	always_ff @(posedge clk) begin
		if (cmd.rd_cap) begin
			case (rtag_q)
				RD_LEN:  flen_q <= rd_val;
				RD_LQI:  lqi_q  <= rd_val[6:0];
				RD_RSSI: rssi_q <= rd_val;
				default: ;
			endcase
		end
	end

	// effect of the finishing transaction
	always_comb begin
		write_slot_nxt = write_slot_q;
		read_slot_nxt  = read_slot_q;
		free_nxt       = free_q;
		capturing_nxt  = capturing_q;
		byte_pos_nxt   = byte_pos_q;
		cur_len_nxt    = cur_len_q;
		status_nxt     = STS_BYTE_IGN;
		plen_nxt       = '0;
		lqi_nxt        = '0;
		rssi_nxt       = '0;
		data_nxt       = '0;
		case (req_q)
			REQ_START: begin
				capturing_nxt = 1'b0;
				status_nxt    = STS_REJECTED;
				if (start_ok) begin
					capturing_nxt = 1'b1;
					byte_pos_nxt  = '0;
					cur_len_nxt   = len_q;
					status_nxt    = STS_ACCEPTED;
				end
			end
			REQ_BYTE: begin
				if (capturing_q) begin
					byte_pos_nxt = byte_pos_q + 8'd1;
					status_nxt   = STS_STORED;
					if (last_byte) begin
						capturing_nxt = 1'b0;
						status_nxt    = STS_CRC_FAIL;
						if (commit_ok) begin
							write_slot_nxt = next_slot(write_slot_q);
							free_nxt       = free_q - CNT_W'(1);
							status_nxt     = STS_COMMITTED;
						end
					end
				end
			end
			REQ_READ: begin
				status_nxt = STS_EMPTY;
				if (!empty) begin
					status_nxt = STS_READ;
					plen_nxt   = plen_cur;
					lqi_nxt    = lqi_q;
					rssi_nxt   = rssi_q;
					data_nxt   = data_now;
				end
			end
			REQ_RELEASE: begin
				status_nxt = STS_REL_IGNORED;
				if (!empty) begin
					read_slot_nxt = next_slot(read_slot_q);
					free_nxt      = free_q + CNT_W'(1);
					status_nxt    = STS_RELEASED;
				end
			end
			REQ_FLUSH: begin
				free_nxt   = ALL_FREE;
				status_nxt = STS_FLUSHED;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			free_q       <= ALL_FREE;
			capturing_q  <= 1'b0;
			byte_pos_q   <= '0;
			cur_len_q    <= '0;
		end else if (cmd.fin) begin
			write_slot_q <= write_slot_nxt;
			read_slot_q  <= read_slot_nxt;
			free_q       <= free_nxt;
			capturing_q  <= capturing_nxt;
			byte_pos_q   <= byte_pos_nxt;
			cur_len_q    <= cur_len_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			status      <= status_nxt;
			payload_len <= plen_nxt;
			lqi         <= lqi_nxt;
			rssi        <= $signed(rssi_nxt);
			data_byte   <= data_nxt;
			free_slots  <= free_nxt[1:0];
		end
	end

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= ALL_FREE)
		else $error("free slot count above slot total");

	a_capture_pos: assert property (@(posedge clk) disable iff (!arst_n)
		capturing_q |-> (byte_pos_q < cur_len_q))
		else $error("capture position past frame length");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(write_slot_q <= LAST_SLOT) && (read_slot_q <= LAST_SLOT))
		else $error("slot pointer out of range");

endmodule

### rtl/core/rfq_ctrl.sv
// controller of the receive frame queue: sequences each transaction and the result handshake
module rfq_ctrl import rfq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.req)
					REQ_BYTE: begin
						cmd.wr_byte = stat.capturing;
						if (stat.capturing && stat.last_byte && stat.commit_ok) begin
							state_nxt = ST_COMMIT;
						end else if (out_free) begin
							cmd.fin   = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					REQ_READ: begin
						if (!stat.empty) begin
							cmd.rd_issue = 1'b1;
							cmd.rd_sel   = RD_LEN;
							state_nxt    = ST_R1;
						end else if (out_free) begin
							cmd.fin   = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							cmd.fin   = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
				endcase
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.wr_rssi = 1'b1;
					cmd.fin     = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			ST_R1: begin
				cmd.rd_cap   = 1'b1;
				cmd.rd_issue = 1'b1;
				cmd.rd_sel   = RD_LQI;
				state_nxt    = ST_R2;
			end
			ST_R2: begin
				cmd.rd_cap   = 1'b1;
				cmd.rd_issue = 1'b1;
				cmd.rd_sel   = RD_RSSI;
				state_nxt    = ST_R3;
			end
			ST_R3: begin
				cmd.rd_cap   = 1'b1;
				cmd.rd_issue = 1'b1;
				cmd.rd_sel   = RD_DATA;
				state_nxt    = ST_R4;
			end
			ST_R4: begin
				if (out_free) begin
					cmd.fin   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted transaction not executed next cycle");

	a_read_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R1) |=> ##1 (state_q == ST_R3))
		else $error("head read sequence broken");

	a_commit_cond: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> (stat.capturing && stat.last_byte && stat.commit_ok))
		else $error("commit without a good completed frame");

endmodule

### rtl/core/radio_rx_frame_queue.sv
// top level of the receive frame queue
// Receive frame queue holding NUM_SLOTS frames of up to SLOT_BYTES bytes each in a
// single-port frame store (one write or one read per cycle). Each request transaction
// yields exactly one response transaction. A request is latched when it is taken and
// executed from the next cycle on; frame start, ordinary frame byte, release, flush and
// rejected requests finish in that execute step; the last byte of a good frame adds a
// commit step, because the signal strength byte is written to the store in a second
// write; a head read issues one store read each for the length, the link quality
// byte, the signal strength byte and the data byte, then a step picks up the data byte.
// A finished response sits in an output register, so the next request is taken while it
// waits; the finishing step of that request holds until the response register is free.
// The frame store has no reset; a head read can return entries no frame has written.
module radio_rx_frame_queue import rfq_pkg::*; #(
	parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
	parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rfq_req_if.sink               rx_req,
	rfq_rsp_if.source             rx_rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;
	logic     out_valid;

	assign rx_req.ready = in_ready;
	assign rx_rsp.valid = out_valid;

	rfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rx_rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rfq_dp #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (rx_req.req_type),
		.frame_length (rx_req.frame_length),
		.first_byte   (rx_req.first_byte),
		.byte_in      (rx_req.byte_in),
		.byte_index   (rx_req.byte_index),
		.status       (rx_rsp.status),
		.payload_len  (rx_rsp.payload_len),
		.lqi          (rx_rsp.lqi),
		.rssi         (rx_rsp.rssi),
		.data_byte    (rx_rsp.data_byte),
		.free_slots   (rx_rsp.free_slots)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the receive frame queue with a built-in queue predictor
module testbench import rfq_pkg::*; ();

	localparam int NSLOT       = DEF_NUM_SLOTS;
	localparam int SLOTB       = DEF_SLOT_BYTES;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [2:0] REQ_TOP_CODE = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] flen;
		logic [7:0] first;
		logic [7:0] data;
		logic [6:0] idx;
	} radio_item_t;

	typedef struct packed {
		logic        [3:0] status;
		logic        [6:0] plen;
		logic        [6:0] lqi;
		logic signed [7:0] rssi;
		logic        [7:0] data;
		logic        [1:0] free;
	} queue_rsp_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rfq_req_if req_ch ();
	rfq_rsp_if rsp_ch ();

	radio_rx_frame_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rx_req   (req_ch),
		.rx_rsp   (rsp_ch)
	);

	// shadow of the queue state
	logic [7:0] q_store [0:NSLOT*SLOTB-1];
	bit         q_written [0:NSLOT*SLOTB-1];
	int         q_wr     = 0;
	int         q_rd     = 0;
	int         free_cnt = NSLOT;
	bit         capt     = 1'b0;
	int         bpos     = 0;
	int         clen     = 0;
	bit         rx_on    = 1'b0;
	logic [7:0] rssi_reg = 8'd0;

	radio_item_t radio_items [$];
	queue_rsp_t  awaited_rsp [$];
	radio_item_t nxt;
	queue_rsp_t  want;

	int items_issued = 0;
	int errors       = 0;
	int n_rsp        = 0;
	int n_commit     = 0;
	int n_crc        = 0;
	int n_read       = 0;
	int n_reject     = 0;
	int cycles       = 0;
	int tx_gap       = 0;
	int rx_stall     = 0;
	int hold_left    = 0;
	bit idling       = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] slot_byte(int slot, int off);
		if (off >= 0 && off < SLOTB)
			return q_store[slot*SLOTB + off];
		return 8'h00;
	endfunction

	function automatic void slot_write(int slot, int off, logic [7:0] v);
		if (off >= 0 && off < SLOTB) begin
			q_store[slot*SLOTB + off]   = v;
			q_written[slot*SLOTB + off] = 1'b1;
		end
	endfunction

	function automatic int slot_after(int s);
		return (s + 1 >= NSLOT) ? 0 : s + 1;
	endfunction

	function automatic queue_rsp_t queue_response(radio_item_t it);
		queue_rsp_t r;
		int         fl;
		int         pl;
		r        = '0;
		r.status = STS_BYTE_IGN;
		case (it.kind)
			REQ_START: begin
				capt = 1'b0;
				if (it.flen < MIN_LEN || it.flen > MAX_LEN || it.first + 8'd1 != it.flen ||
				    !rx_on || free_cnt == 0) begin
					r.status = STS_REJECTED;
				end else begin
					slot_write(q_wr, 0, it.flen);
					capt     = 1'b1;
					bpos     = 0;
					clen     = it.flen;
					r.status = STS_ACCEPTED;
				end
			end
			REQ_BYTE: begin
				if (capt) begin
					slot_write(q_wr, 1 + bpos, it.data);
					bpos++;
					r.status = STS_STORED;
					if (bpos >= clen) begin
						capt = 1'b0;
						if ((slot_byte(q_wr, clen) & 8'h80) == 0 || free_cnt == 0) begin
							r.status = STS_CRC_FAIL;
						end else begin
							slot_write(q_wr, clen - 1, rssi_reg - RSSI_OFFSET);
							q_wr     = slot_after(q_wr);
							free_cnt--;
							r.status = STS_COMMITTED;
						end
					end
				end
			end
			REQ_READ: begin
				if (free_cnt >= NSLOT) begin
					r.status = STS_EMPTY;
				end else begin
					fl     = slot_byte(q_rd, 0);
					pl     = (fl - 2) & 'h7f;
					r.plen = pl;
					r.lqi  = slot_byte(q_rd, fl) & 8'h7f;
					r.rssi = slot_byte(q_rd, fl - 1);
					if (it.idx < pl)
						r.data = slot_byte(q_rd, 1 + it.idx);
					r.status = STS_READ;
				end
			end
			REQ_RELEASE: begin
				if (free_cnt >= NSLOT) begin
					r.status = STS_REL_IGNORED;
				end else begin
					q_rd     = slot_after(q_rd);
					free_cnt++;
					r.status = STS_RELEASED;
				end
			end
			REQ_FLUSH: begin
				free_cnt = NSLOT;
				r.status = STS_FLUSHED;
			end
			default: ;
		endcase
		r.free = free_cnt[1:0];
		return r;
	endfunction

	// a head read that would touch a never-written byte becomes a release
	task automatic issue(radio_item_t it);
		int fl;
		int base;
		bit ok;
		if (it.kind == REQ_READ && free_cnt < NSLOT) begin
			base = q_rd * SLOTB;
			ok   = q_written[base];
			fl   = q_store[base];
			if (ok && fl < SLOTB)
				ok = q_written[base + fl];
			if (ok && fl - 1 < SLOTB)
				ok = q_written[base + fl - 1];
			if (ok && it.idx < ((fl - 2) & 'h7f))
				ok = q_written[base + 1 + it.idx];
			if (!ok)
				it.kind = REQ_RELEASE;
		end
		radio_items.push_back(it);
		awaited_rsp.push_back(queue_response(it));
		items_issued++;
	endtask

	function automatic radio_item_t random_item(logic [2:0] kind);
		radio_item_t it;
		it.kind  = kind;
		it.flen  = $urandom;
		it.first = $urandom;
		it.data  = $urandom;
		it.idx   = $urandom;
		return it;
	endfunction

	task automatic simple(logic [2:0] kind);
		issue(random_item(kind));
	endtask

	task automatic frame_start(int len, int first);
		radio_item_t it;
		it       = random_item(REQ_START);
		it.flen  = len;
		it.first = first;
		issue(it);
	endtask

	task automatic frame_bytes(int len, int count, bit good);
		radio_item_t it;
		for (int i = 0; i < count; i++) begin
			it = random_item(REQ_BYTE);
			if (i == len - 1)
				it.data[7] = good;
			issue(it);
		end
	endtask

	task automatic read_head(int idx);
		radio_item_t it;
		it     = random_item(REQ_READ);
		it.idx = idx;
		issue(it);
	endtask

	task automatic random_traffic(int n);
		radio_item_t it;
		int          stop;
		int          pick;
		int          len;
		int          keep;
		stop = items_issued + n;
		while (items_issued < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if (free_cnt == 0 && $urandom_range(0, 3) != 0) begin
					simple(REQ_RELEASE);
				end else begin
					pick = $urandom_range(0, 99);
					len  = (pick < 88) ? $urandom_range(3, 16) :
					       (pick < 96) ? $urandom_range(17, 126) : MAX_LEN;
					keep = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
					frame_start(len, len - 1);
					frame_bytes(len, keep, $urandom_range(0, 7) != 0);
				end
			end else if (pick < 65) begin
				read_head($urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 15));
			end else if (pick < 82) begin
				simple(REQ_RELEASE);
			end else if (pick < 86) begin
				simple(REQ_FLUSH);
			end else if (pick < 90) begin
				it = random_item(REQ_START);
				if ($urandom_range(0, 1))
					it.first = it.flen - 8'd1;
				issue(it);
			end else if (pick < 94) begin
				simple(REQ_BYTE);
			end else if (pick < 97) begin
				simple($urandom_range(REQ_FLUSH + 1, REQ_TOP_CODE));
			end else begin
				// abandoned capture, restarted by the next frame
				len = $urandom_range(3, 16);
				frame_start(len, len - 1);
				frame_bytes(len, $urandom_range(0, len - 1), 1'b1);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CFG_RX_ENABLE)
			rx_on = val[0];
		else
			rssi_reg = val;
	endtask

	task automatic drain();
		while (awaited_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic field_check(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n && !(req_ch.valid && !req_ch.ready)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				req_ch.valid <= 1'b0;
			end else if (radio_items.size() != 0) begin
				nxt = radio_items.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.req_type     <= nxt.kind;
				req_ch.frame_length <= nxt.flen;
				req_ch.first_byte   <= nxt.first;
				req_ch.byte_in      <= nxt.data;
				req_ch.byte_index   <= nxt.idx;
				if (idling && $urandom_range(0, 4) == 0)
					tx_gap = $urandom_range(1, 4);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_rsp++;
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, expected none got status %0d",
					         $time, rsp_ch.status);
				end else begin
					want = awaited_rsp.pop_front();
					field_check("status", want.status, rsp_ch.status);
					field_check("payload_len", want.plen, rsp_ch.payload_len);
					field_check("lqi", want.lqi, rsp_ch.lqi);
					field_check("rssi", want.rssi, rsp_ch.rssi);
					field_check("data_byte", want.data, rsp_ch.data_byte);
					field_check("free_slots", want.free, rsp_ch.free_slots);
				end
				case (rsp_ch.status)
					STS_COMMITTED: n_commit++;
					STS_CRC_FAIL:  n_crc++;
					STS_READ:      n_read++;
					STS_REJECTED:  n_reject++;
					default: ;
				endcase
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idling && $urandom_range(0, 5) == 0)
					rx_stall = $urandom_range(1, 4);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		cfg_we              = 1'b0;
		cfg_idx             = '0;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = '0;
		req_ch.frame_length = '0;
		req_ch.first_byte   = '0;
		req_ch.byte_in      = '0;
		req_ch.byte_index   = '0;
		rsp_ch.ready        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reception off after reset, empty queue
		frame_start(5, 4);
		simple(REQ_BYTE);
		read_head(0);
		simple(REQ_RELEASE);
		simple(REQ_FLUSH + 1);
		simple(REQ_TOP_CODE);
		drain();
		write_reg(CFG_RX_ENABLE, 8'd1);
		write_reg(CFG_RSSI_RAW, 8'hff);

		// length and first byte checks
		frame_start(2, 1);
		frame_start(128, 127);
		frame_start(3, 0);
		frame_start(255, 254);
		frame_start(0, 255);
		frame_start(3, 2);
		frame_bytes(3, 3, 1'b1);
		read_head(0);
		read_head(127);
		// restart mid-capture, then a bad crc
		frame_start(4, 3);
		frame_bytes(4, 1, 1'b1);
		frame_start(3, 2);
		frame_bytes(3, 3, 1'b0);
		simple(REQ_FLUSH);
		read_head(1);
		simple(REQ_RELEASE);
		drain();

		write_reg(CFG_RSSI_RAW, 8'd0);
		random_traffic(400);
		drain();

		// receiver holds off while requests keep coming
		write_reg(CFG_RSSI_RAW, 8'h80);
		hold_left = 300;
		random_traffic(400);
		drain();

		write_reg(CFG_RX_ENABLE, 8'd0);
		write_reg(CFG_RSSI_RAW, $urandom);
		random_traffic(100);
		drain();

		write_reg(CFG_RX_ENABLE, 8'd1);
		write_reg(CFG_RSSI_RAW, RSSI_OFFSET);
		random_traffic(350);
		drain();

		idling = 1'b0;
		random_traffic(350);
		drain();
		repeat (10) @(negedge clk);

		$display("covered %0d items and %0d response transactions, %0d mismatches",
		         items_issued, n_rsp, errors);
		$display("frames committed %0d, crc drops %0d, head reads %0d, rejects %0d",
		         n_commit, n_crc, n_read, n_reject);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### files.f
rtl/core/rfq_pkg.sv
rtl/core/rfq_if.sv
rtl/core/rfq_dp.sv
rtl/core/rfq_ctrl.sv
rtl/core/radio_rx_frame_queue.sv
bench/testbench.sv
